// ===== rtl/core/tlt_pkg.sv =====
// Package for the template-language tokenizer: token kinds, scan modes,
// character classes and the keyword table. No dependencies.
`default_nettype none
package tlt_pkg;

	localparam int LINE_BITS_DEF   = 20;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int OUT_LINE_W      = 20;
	localparam int OUT_COL_W       = 16;

	localparam logic [5:0] K_IDENT   = 6'd22;
	localparam logic [5:0] K_INT     = 6'd23;
	localparam logic [5:0] K_STRING  = 6'd24;
	localparam logic [5:0] K_NEWLINE = 6'd25;
	localparam logic [5:0] K_END     = 6'd26;
	localparam logic [5:0] K_ERROR   = 6'd27;
	localparam logic [5:0] K_PLUS    = 6'd28;
	localparam logic [5:0] K_EQEQ    = 6'd37;
	localparam logic [5:0] K_ASSIGN  = 6'd38;
	localparam logic [5:0] K_NOTEQ   = 6'd39;
	localparam logic [5:0] K_GE      = 6'd40;
	localparam logic [5:0] K_GT      = 6'd41;
	localparam logic [5:0] K_LE      = 6'd42;
	localparam logic [5:0] K_LT      = 6'd43;

	localparam logic [1:0] E_NONE     = 2'd0;
	localparam logic [1:0] E_UNTERM   = 2'd1;
	localparam logic [1:0] E_BAD_CHAR = 2'd2;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_UND   = 8'h5F;

	typedef enum logic [6:0] {
		M_START    = 7'b0000001,
		M_WORD     = 7'b0000010,
		M_NUMBER   = 7'b0000100,
		M_STRING   = 7'b0001000,
		M_COMMENT  = 7'b0010000,
		M_OPERATOR = 7'b0100000,
		M_CONTINUE = 7'b1000000
	} scan_mode_t;

	typedef struct packed {
		logic            is_token;
		logic [5:0]      token_kind;
		logic [7:0]      text_char;
		logic [1:0]      error_code;
	} rec_t;

	typedef logic [63:0] word_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UND;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// single-character operators: + - * / ( ) { } .
	function automatic logic [4:0] single_op(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h1F;
		case (c)
			8'h2B: r = 5'd0;
			8'h2D: r = 5'd1;
			8'h2A: r = 5'd2;
			8'h2F: r = 5'd3;
			8'h28: r = 5'd4;
			8'h29: r = 5'd5;
			8'h7B: r = 5'd6;
			8'h7D: r = 5'd7;
			8'h2E: r = 5'd8;
			default: r = 5'h1F;
		endcase
		return r;
	endfunction

	// keyword text, first char in the low byte, zero padded
	function automatic word_t kw_text(input int i);
		word_t w;
		case (i)
			0:  w = 64'h00000000006B7361; // ask
			1:  w = 64'h000000000074656C; // let
			2:  w = 64'h000000726964_6B6D; // mkdir
			3:  w = 64'h00000000656C6966; // file
			4:  w = 64'h000000006D6F7266; // from
			5:  w = 64'h00746E65746E6F63; // content
			6:  w = 64'h000000006E656877; // when
			7:  w = 64'h0000746165706572; // repeat
			8:  w = 64'h0000000000646E65; // end
			9:  w = 64'h6465726975716572; // required
			10: w = 64'h6D69746162726576; // verbatim
			11: w = 64'h0000646E65707061; // append
			12: w = 64'h0000000065646F6D; // mode
			13: w = 64'h0000000000007361; // as
			14: w = 64'h0000000000646E61; // and
			15: w = 64'h000000000000726F; // or
			16: w = 64'h0000000000746F6E; // not
			17: w = 64'h0000676E69727473; // string
			18: w = 64'h000000006C6F6F62; // bool
			19: w = 64'h0000000000746E69; // int
			20: w = 64'h0000000065757274; // true
			default: w = 64'h00000065736C6166; // false
		endcase
		return w;
	endfunction

	function automatic logic [3:0] kw_len(input int i);
		logic [3:0] l;
		case (i)
			0, 1, 8, 14, 16, 19: l = 4'd3;
			13, 15:              l = 4'd2;
			2, 21:               l = 4'd5;
			5:                   l = 4'd7;
			7, 11, 17:           l = 4'd6;
			9, 10:               l = 4'd8;
			default:             l = 4'd4;
		endcase
		return l;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tlt_if.sv =====
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; payload type given by parameter.
`default_nettype none
interface tlt_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tlt_kw_match.sv =====
// Parallel keyword compare of the buffered word against the 22 keywords.
// Depends on tlt_pkg.
`default_nettype none
module tlt_kw_match import tlt_pkg::*; (
	input  wire word_t      word,
	input  wire logic [3:0] len,
	output logic [5:0]      kind
);
	// mask bytes beyond the length, compare with the zero-padded table
	always_comb begin
		word_t m;
		m = '0;
		for (int b = 0; b < 8; b++)
			if (4'(b) < len) m[b*8 +: 8] = word[b*8 +: 8];
		kind = K_IDENT;
		for (int i = 21; i >= 0; i--)
			if (len == kw_len(i) && m == kw_text(i)) kind = 6'(i);
	end
endmodule
`default_nettype wire

// ===== rtl/core/template_language_tokenizer_unit.sv =====
// Top level of the template-language tokenizer.
// Depends on tlt_pkg, tlt_if and tlt_kw_match.
//
// Takes one source byte (or the end marker) per beat and produces zero, one
// or two result beats per input beat. The results of a beat are computed in
// the accepting cycle from the input byte, the mode register and a parallel
// keyword compare, and land in a two-entry output buffer; the first result is
// offered on the cycle after the input beat. An input beat is taken while the
// buffer is empty or holds one result that leaves in the same cycle. Beats
// with at most one result can therefore follow back to back; after a beat
// with two results the next one is taken only as the second leaves, set by
// the single result port. Stalls on the result side hold off the input.
`default_nettype none
module template_language_tokenizer_unit import tlt_pkg::*; #(
	parameter int LINE_BITS   = LINE_BITS_DEF,
	parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	tlt_if.sink      in_ch,
	tlt_if.source    out_ch
);
	localparam logic [LINE_BITS-1:0]   LMAX = '1;
	localparam logic [COLUMN_BITS-1:0] CMAX = '1;

	scan_mode_t             mode_q;
	word_t                  wbuf_q;
	logic [3:0]             wlen_q;
	logic [7:0]             pend_q;
	logic [LINE_BITS-1:0]   line_q, tline_q;
	logic [COLUMN_BITS-1:0] col_q, tcol_q;

	wire logic [7:0] c   = in_ch.data.source_char;
	wire logic       eos = in_ch.data.end_of_source;
	wire logic       acc = in_ch.valid & in_ch.ready;

	logic [5:0] wkind;
	tlt_kw_match u_kw (.word(wbuf_q), .len(wlen_q), .kind(wkind));

	// next-state and result logic
	rec_t                   r0, r1;
	logic [1:0]             n;
	logic                   r0_at_cur; // first record uses the position of this byte
	logic                   r1_at_cur; // second record uses the position of this byte
	scan_mode_t             mode_d;
	word_t                  wbuf_d;
	logic [3:0]             wlen_d;
	logic [7:0]             pend_d;
	logic [LINE_BITS-1:0]   line_d, tline_d;
	logic [COLUMN_BITS-1:0] col_d, tcol_d;
	logic                   rst_all;

	function automatic rec_t mk(input logic t, input logic [5:0] k,
		input logic [7:0] ch, input logic [1:0] e);
		rec_t r;
		r.is_token = t; r.token_kind = k; r.text_char = ch; r.error_code = e;
		return r;
	endfunction

	function automatic rec_t op_rec(input logic [7:0] p, input logic eq);
		rec_t r;
		priority if (p == CH_EQ) r = mk(1'b1, eq ? K_EQEQ : K_ASSIGN, 8'h0, E_NONE);
		else if (p == CH_GT) r = mk(1'b1, eq ? K_GE : K_GT, 8'h0, E_NONE);
		else if (p == CH_LT) r = mk(1'b1, eq ? K_LE : K_LT, 8'h0, E_NONE);
		else if (eq) r = mk(1'b1, K_NOTEQ, 8'h0, E_NONE);
		else r = mk(1'b1, K_ERROR, CH_BANG, E_BAD_CHAR);
		return r;
	endfunction

	always_comb begin
		logic       do_start;
		logic       s_emit;
		rec_t       s_rec;
		scan_mode_t s_mode;
		logic       s_mark;
		logic [4:0] so;
		mode_d = mode_q; wbuf_d = wbuf_q; wlen_d = wlen_q; pend_d = pend_q;
		line_d = line_q; col_d = col_q; tline_d = tline_q; tcol_d = tcol_q;
		r0 = '0; r1 = '0; n = 2'd0; r0_at_cur = 1'b0; r1_at_cur = 1'b0;
		rst_all = 1'b0;
		do_start = 1'b0;

		// start-of-token scan of c
		so = single_op(c);
		s_emit = 1'b0; s_rec = '0; s_mode = M_START;
		s_mark = !(c == CH_SPACE || c == CH_TAB);
		if (s_mark) begin
			priority if (c == CH_BSL) s_mode = M_CONTINUE;
			else if (c == CH_NL) begin
				s_emit = 1'b1; s_rec = mk(1'b1, K_NEWLINE, 8'h0, E_NONE);
			end else if (c == CH_HASH) s_mode = M_COMMENT;
			else if (is_alpha(c)) begin
				s_mode = M_WORD; s_emit = 1'b1; s_rec = mk(1'b0, K_IDENT, c, E_NONE);
			end else if (c == CH_QUOTE) s_mode = M_STRING;
			else if (is_digit(c)) begin
				s_mode = M_NUMBER; s_emit = 1'b1; s_rec = mk(1'b0, K_INT, c, E_NONE);
			end else if (c == CH_EQ || c == CH_BANG || c == CH_GT || c == CH_LT)
				s_mode = M_OPERATOR;
			else if (so != 5'h1F) begin
				s_emit = 1'b1; s_rec = mk(1'b1, K_PLUS + 6'(so), 8'h0, E_NONE);
			end else begin
				s_emit = 1'b1; s_rec = mk(1'b1, K_ERROR, c, E_BAD_CHAR);
			end
		end

		if (eos) begin
			// flush, then end record at the current position
			rst_all = 1'b1;
			r1 = mk(1'b1, K_END, 8'h0, E_NONE);
			unique case (mode_q)
				M_WORD:     r0 = mk(1'b1, wkind, 8'h0, E_NONE);
				M_NUMBER:   r0 = mk(1'b1, K_INT, 8'h0, E_NONE);
				M_STRING:   r0 = mk(1'b1, K_ERROR, 8'h0, E_UNTERM);
				M_OPERATOR: r0 = op_rec(pend_q, 1'b0);
				M_CONTINUE: r0 = mk(1'b1, K_ERROR, CH_BSL, E_BAD_CHAR);
				default:    r0 = '0;
			endcase
			if (mode_q == M_START || mode_q == M_COMMENT) begin
				r0 = r1; n = 2'd1; r0_at_cur = 1'b1;
			end else begin
				n = 2'd2;
			end
			r1_at_cur = 1'b1;
		end else begin
			unique case (mode_q)
				M_WORD: begin
					if (is_alpha(c) || is_digit(c)) begin
						if (wlen_q < 4'd8) wbuf_d[wlen_q[2:0]*8 +: 8] = c;
						if (wlen_q < 4'd9) wlen_d = wlen_q + 4'd1;
						r0 = mk(1'b0, K_IDENT, c, E_NONE); n = 2'd1;
					end else begin
						r0 = mk(1'b1, wkind, 8'h0, E_NONE); n = 2'd1; do_start = 1'b1;
					end
				end
				M_NUMBER: begin
					if (is_digit(c)) begin
						r0 = mk(1'b0, K_INT, c, E_NONE); n = 2'd1;
					end else begin
						r0 = mk(1'b1, K_INT, 8'h0, E_NONE); n = 2'd1; do_start = 1'b1;
					end
				end
				M_STRING: begin
					n = 2'd1;
					if (c == CH_QUOTE) begin
						r0 = mk(1'b1, K_STRING, 8'h0, E_NONE); mode_d = M_START;
					end else r0 = mk(1'b0, K_STRING, c, E_NONE);
				end
				M_COMMENT: if (c == CH_NL) do_start = 1'b1;
				M_OPERATOR: begin
					n = 2'd1;
					if (c == CH_EQ) begin
						r0 = op_rec(pend_q, 1'b1); mode_d = M_START;
					end else begin
						r0 = op_rec(pend_q, 1'b0); do_start = 1'b1;
					end
				end
				M_CONTINUE: begin
					if (c == CH_NL) mode_d = M_START;
					else if (c != CH_SPACE && c != CH_TAB) begin
						r0 = mk(1'b1, K_ERROR, CH_BSL, E_BAD_CHAR); n = 2'd1;
						do_start = 1'b1;
					end
				end
				default: do_start = 1'b1;
			endcase
			if (do_start) begin
				mode_d = s_mode;
				if (s_mark) begin tline_d = line_q; tcol_d = col_q; end
				if (s_mode == M_WORD) begin
					wbuf_d[7:0] = c; wlen_d = 4'd1;
				end
				if (s_mode == M_OPERATOR) pend_d = c;
				if (s_emit) begin
					if (n == 2'd0) begin r0 = s_rec; n = 2'd1; r0_at_cur = 1'b1; end
					else begin r1 = s_rec; n = 2'd2; r1_at_cur = 1'b1; end
				end
			end
			// position advance
			if (c == CH_NL) begin
				if (line_q != LMAX) line_d = line_q + 1'b1;
				col_d = COLUMN_BITS'(1);
			end else if (col_q != CMAX) col_d = col_q + 1'b1;
		end
	end

	// positions of the two records: records of the running token use its
	// start, start-scan and end records use the position of this byte
	logic [LINE_BITS-1:0]   l0, l1;
	logic [COLUMN_BITS-1:0] c0, c1;
	always_comb begin
		l0 = r0_at_cur ? line_q : tline_q;
		c0 = r0_at_cur ? col_q : tcol_q;
		l1 = r1_at_cur ? line_q : tline_q;
		c1 = r1_at_cur ? col_q : tcol_q;
	end

	// two-entry output buffer
	typedef struct packed {
		rec_t                   rec;
		logic [OUT_LINE_W-1:0]  line;
		logic [OUT_COL_W-1:0]   col;
		logic                   last;
	} ent_t;
	ent_t       buf_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;

	function automatic ent_t mke(input rec_t r, input logic [LINE_BITS-1:0] l,
		input logic [COLUMN_BITS-1:0] cl, input logic lst);
		ent_t e;
		e.rec = r;
		e.line = OUT_LINE_W'({{(LINE_BITS >= OUT_LINE_W ? 1 : OUT_LINE_W-LINE_BITS+1){1'b0}}, l});
		e.col = OUT_COL_W'({{(COLUMN_BITS >= OUT_COL_W ? 1 : OUT_COL_W-COLUMN_BITS+1){1'b0}}, cl});
		e.last = lst;
		return e;
	endfunction

	wire logic pop = out_ch.valid & out_ch.ready;
	assign in_ch.ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
	assign out_ch.valid = cnt_q != 2'd0;
	always_comb begin
		out_ch.data.is_token     = buf_q[rd_q].rec.is_token;
		out_ch.data.token_kind   = buf_q[rd_q].rec.token_kind;
		out_ch.data.text_char    = buf_q[rd_q].rec.text_char;
		out_ch.data.first_line   = buf_q[rd_q].line;
		out_ch.data.first_column = buf_q[rd_q].col;
		out_ch.data.error_code   = buf_q[rd_q].rec.error_code;
		out_ch.data.last_of_run  = buf_q[rd_q].last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0; rd_q <= 1'b0;
			mode_q <= M_START; wlen_q <= 4'd0; pend_q <= 8'h0;
			line_q <= LINE_BITS'(1); col_q <= COLUMN_BITS'(1);
			tline_q <= LINE_BITS'(1); tcol_q <= COLUMN_BITS'(1);
		end else begin
			logic       wr;
			logic [1:0] cnt;
			logic       rd;
			cnt = cnt_q; rd = rd_q;
			if (pop) begin cnt = cnt - 2'd1; rd = ~rd; end
			wr = rd ^ cnt[0];
			if (acc) begin
				if (n != 2'd0) begin
					buf_q[wr] <= mke(r0, l0, c0, n == 2'd1);
				end
				if (n == 2'd2) buf_q[~wr] <= mke(r1, l1, c1, 1'b1);
				cnt = cnt + n;
				if (rst_all) begin
					mode_q <= M_START; wlen_q <= 4'd0; pend_q <= 8'h0;
					line_q <= LINE_BITS'(1); col_q <= COLUMN_BITS'(1);
					tline_q <= LINE_BITS'(1); tcol_q <= COLUMN_BITS'(1);
				end else begin
					mode_q <= mode_d; wlen_q <= wlen_d; pend_q <= pend_d;
					line_q <= line_d; col_q <= col_d;
					tline_q <= tline_d; tcol_q <= tcol_d;
				end
			end
			cnt_q <= cnt; rd_q <= rd;
		end
	end
	always_ff @(posedge clk) if (acc) wbuf_q <= wbuf_d;

	// checks
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("output buffer overflow");
	a_no_acc_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !in_ch.ready) else $error("accept while buffer full");
	a_wlen: assert property (@(posedge clk) disable iff (!arst_n) wlen_q <= 4'd9)
		else $error("word length out of range");
	a_eos_reset: assert property (@(posedge clk) disable iff (!arst_n)
		acc && eos |=> mode_q == M_START && wlen_q == 4'd0)
		else $error("end beat did not reset scanner");
endmodule
`default_nettype wire
